// ----- rtl/swrl_pkg.sv -----
// Package: types, constants and codes of the sliding window read rate limiter.
`default_nettype none
package swrl_pkg;

   localparam int DATA_W        = 32;
   localparam int TOTAL_W       = 40;
   localparam int CSR_INDEX_W   = 2;
   localparam int HISTORY_DEPTH_DEFAULT = 64;

   localparam logic [DATA_W-1:0] SPEED_LIMIT_RESET = 32'd204800;
   localparam logic [DATA_W-1:0] WINDOW_MS_RESET   = 32'd10000;

   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_MS   = 2'd1;

   // product of duration total and speed limit, then divided by MS_PER_S
   localparam int PROD_W    = TOTAL_W + DATA_W;
   localparam int MS_PER_S  = 1000;
   localparam int DIGIT_W   = 4;
   localparam int DIV_STEPS = PROD_W / DIGIT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int REM_W     = $clog2(MS_PER_S);
   localparam int DVAL_W    = REM_W + DIGIT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHECK,
      ST_RETIRE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV,
      ST_GRANT,
      ST_EVICT,
      ST_APPEND
   } state_type;

   typedef struct packed {
      logic load;
      logic add;
      logic retire;
      logic mul_lo;
      logic mul_hi;
      logic div_step;
      logic grant;
      logic evict;
      logic append;
   } cmd_type;

   typedef struct packed {
      logic retire_needed;
      logic limit_on;
      logic hist_full;
      logic div_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/swrl_req_if.sv -----
// Interface: readiness event channel.
`default_nettype none
interface swrl_req_if;
   import swrl_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] elapsed_ms;
   logic [DATA_W-1:0] available_bytes;

   modport source (output valid, output elapsed_ms, output available_bytes, input ready);
   modport sink   (input valid, input elapsed_ms, input available_bytes, output ready);
endinterface
`default_nettype wire

// ----- rtl/swrl_rsp_if.sv -----
// Interface: grant result channel.
`default_nettype none
interface swrl_rsp_if;
   import swrl_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_size;
   logic              more_pending;

   modport source (output valid, output read_size, output more_pending, input ready);
   modport sink   (input valid, input read_size, input more_pending, output ready);
endinterface
`default_nettype wire

// ----- rtl/swrl_csr_if.sv -----
// Interface: configuration register write channel.
`default_nettype none
interface swrl_csr_if;
   import swrl_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/swrl_ctrl.sv -----
// Controller: sequences one readiness event through the datapath.
`default_nettype none
module swrl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire swrl_pkg::status_type status,
   output swrl_pkg::cmd_type       cmd
);
   import swrl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ADD;
         end
         ST_ADD:    state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.retire_needed) state_in = ST_RETIRE;
            else if (status.limit_on) state_in = ST_MUL_LO;
            else                      state_in = ST_GRANT;
         end
         ST_RETIRE: state_in = ST_CHECK;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = ST_GRANT;
         end
         ST_GRANT: begin
            state_in = status.hist_full ? ST_EVICT : ST_APPEND;
         end
         ST_EVICT:  state_in = ST_APPEND;
         ST_APPEND: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid;
         end
         ST_ADD:    cmd.add      = 1'b1;
         ST_CHECK:  cmd          = '0;
         ST_RETIRE: cmd.retire   = 1'b1;
         ST_MUL_LO: cmd.mul_lo   = 1'b1;
         ST_MUL_HI: cmd.mul_hi   = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_GRANT:  cmd.grant    = 1'b1;
         ST_EVICT:  cmd.evict    = 1'b1;
         ST_APPEND: cmd.append   = status.out_free;
         default:   cmd          = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/swrl_dp.sv -----
// Datapath: totals, history memory, multiplier, divide-by-1000 unit, result register.
`default_nettype none
module swrl_dp #(
   parameter int HISTORY_DEPTH = swrl_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire swrl_pkg::cmd_type                 cmd,
   output swrl_pkg::status_type                   status,
   input  wire logic [swrl_pkg::DATA_W-1:0]       req_elapsed_ms,
   input  wire logic [swrl_pkg::DATA_W-1:0]       req_available_bytes,
   input  wire logic                              csr_valid,
   input  wire logic [swrl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [swrl_pkg::DATA_W-1:0]       csr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [swrl_pkg::DATA_W-1:0]            rsp_read_size,
   output logic                                   rsp_more_pending
);
   import swrl_pkg::*;

   localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = HEAD_W + 1;
   localparam int ENTRY_W = 2 * DATA_W;

   // configuration
   logic [DATA_W-1:0] speed_ff;
   logic [DATA_W-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_LIMIT_RESET;
         window_ff <= WINDOW_MS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SPEED_LIMIT: speed_ff  <= csr_data;
            REG_WINDOW_MS:   window_ff <= csr_data;
            default:         speed_ff  <= speed_ff;
         endcase
      end
   end

   // event operands
   logic [DATA_W-1:0] elapsed_ff;
   logic [DATA_W-1:0] avail_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elapsed_ff <= req_elapsed_ms;
         avail_ff   <= req_available_bytes;
      end
   end

   // history memory and pointers
   logic [ENTRY_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic [HEAD_W-1:0]  head_ff;
   logic [HEAD_W-1:0]  head_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [SUM_W-1:0]   slot_sum;
   logic [HEAD_W-1:0]  slot;
   logic [HEAD_W-1:0]  head_next;
   logic [DATA_W-1:0]  grant_ff;
   logic [DATA_W-1:0]  grant_in;

   assign slot_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign slot      = (slot_sum >= SUM_W'(HISTORY_DEPTH)) ?
                      HEAD_W'(slot_sum - SUM_W'(HISTORY_DEPTH)) : HEAD_W'(slot_sum);
   assign head_next = (head_ff == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         hist_mem[slot] <= {elapsed_ff, grant_ff};
      end
      rd_ff <= hist_mem[head_ff];
   end

   // totals
   logic [TOTAL_W-1:0] td_ff;
   logic [TOTAL_W-1:0] td_in;
   logic [TOTAL_W-1:0] tb_ff;
   logic [TOTAL_W-1:0] tb_in;
   logic [TOTAL_W:0]   td_sum;
   logic [TOTAL_W-1:0] rd_dur;
   logic [TOTAL_W-1:0] rd_bytes;
   logic [TOTAL_W-1:0] td_less;
   logic [TOTAL_W-1:0] tb_less;
   logic               drop;

   assign td_sum   = {1'b0, td_ff} + (TOTAL_W+1)'(elapsed_ff);
   assign rd_dur   = TOTAL_W'(rd_ff[ENTRY_W-1:DATA_W]);
   assign rd_bytes = TOTAL_W'(rd_ff[DATA_W-1:0]);
   assign td_less  = (td_ff > rd_dur) ? td_ff - rd_dur : '0;
   assign tb_less  = (tb_ff > rd_bytes) ? tb_ff - rd_bytes : '0;
   assign drop     = cmd.retire | cmd.evict;

   always_comb begin
      td_in    = td_ff;
      tb_in    = tb_ff;
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.add) begin
         td_in = td_sum[TOTAL_W] ? '1 : td_sum[TOTAL_W-1:0];
      end
      if (drop) begin
         td_in    = td_less;
         tb_in    = tb_less;
         head_in  = head_next;
         count_in = count_ff - 1'b1;
      end
      if (cmd.append) begin
         tb_in    = tb_ff + TOTAL_W'(grant_ff);
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         td_ff    <= '0;
         tb_ff    <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         td_ff    <= td_in;
         tb_ff    <= tb_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // multiplier and radix-16 divide by MS_PER_S
   logic [DATA_W-1:0]    mul_a;
   logic [2*DATA_W-1:0]  mul_p;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W-1:0]    prod_in;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIV_CNT_W-1:0] div_cnt_in;
   logic [DVAL_W-1:0]    dval;
   logic [DIGIT_W-1:0]   qdig;
   logic [DVAL_W-1:0]    qsub;

   assign mul_a = cmd.mul_hi ? DATA_W'(td_ff[TOTAL_W-1:DATA_W]) : td_ff[DATA_W-1:0];
   assign mul_p = {{DATA_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, speed_ff};
   assign dval  = {rem_ff, prod_ff[PROD_W-1 -: DIGIT_W]};

   always_comb begin
      qdig = '0;
      qsub = '0;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (dval >= DVAL_W'(k * MS_PER_S)) begin
            qdig = DIGIT_W'(k);
            qsub = DVAL_W'(k * MS_PER_S);
         end
      end
   end

   always_comb begin
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.mul_lo) begin
         prod_in    = PROD_W'(mul_p);
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.mul_hi) begin
         prod_in = prod_ff + {mul_p[PROD_W-DATA_W-1:0], {DATA_W{1'b0}}};
      end else if (cmd.div_step) begin
         prod_in    = {prod_ff[PROD_W-DIGIT_W-1:0], qdig};
         rem_in     = REM_W'(dval - qsub);
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   // grant
   logic [PROD_W-1:0] tb_wide;
   logic [PROD_W-1:0] diff;

   assign tb_wide = PROD_W'(tb_ff);
   assign diff    = prod_ff - tb_wide;

   always_comb begin
      grant_in = grant_ff;
      if (cmd.grant) begin
         if (!status.limit_on) begin
            grant_in = avail_ff;
         end else if (prod_ff <= tb_wide) begin
            grant_in = '0;
         end else if (diff < PROD_W'(avail_ff)) begin
            grant_in = diff[DATA_W-1:0];
         end else begin
            grant_in = avail_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      grant_ff <= grant_in;
   end

   // result register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] read_size_ff;
   logic              more_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.append) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         read_size_ff <= grant_ff;
         more_ff      <= (avail_ff > grant_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_size    = read_size_ff;
   assign rsp_more_pending = more_ff;

   assign status.retire_needed = (td_ff > TOTAL_W'(window_ff)) && (count_ff != '0);
   assign status.limit_on      = (td_ff != '0) && (speed_ff != '0);
   assign status.hist_full     = (count_ff == CNT_W'(HISTORY_DEPTH));
   assign status.div_last      = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.out_free      = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ----- rtl/sliding_window_read_rate_limiter_unit.sv -----
// Top level: sliding window read rate limiter.
//
//  channel   dir  payload                        transfer when
//  req_chan  in   elapsed_ms, available_bytes    valid & ready
//  rsp_chan  out  read_size, more_pending        valid & ready
//  csr_chan  in   index, data                    valid & ready (ready high out of reset)
//
// One event at a time. Without limiting an event passes the add and check steps,
// a retire step per retired history entry, then grant and append; with limiting
// it adds the 2-pass 32x32 multiply and the 18-step radix-16 divide by 1000.
// A full history adds an evict step for the oldest entry.
// The result sits in an output register, so the next event is taken while it
// waits; a stalled result holds the following event at its commit step.
// Reset is synchronous; no clearing pass, history entries are tracked by count.
`default_nettype none
module sliding_window_read_rate_limiter_unit #(
   parameter int HISTORY_DEPTH = swrl_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swrl_req_if.sink   req_chan,
   swrl_rsp_if.source rsp_chan,
   swrl_csr_if.sink   csr_chan
);
   import swrl_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   swrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swrl_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_elapsed_ms      (req_chan.elapsed_ms),
      .req_available_bytes (req_chan.available_bytes),
      .csr_valid           (csr_chan.valid),
      .csr_index           (csr_chan.index),
      .csr_data            (csr_chan.data),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_read_size       (rsp_chan.read_size),
      .rsp_more_pending    (rsp_chan.more_pending)
   );

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = !reset;

endmodule
`default_nettype wire

// ----- tb/tb_sliding_window_read_rate_limiter_unit.sv -----
// Testbench: sliding window read rate limiter, directed and random events checked against a predictor.
`default_nettype none
module tb_sliding_window_read_rate_limiter_unit;
   import swrl_pkg::*;

   localparam int DEPTH = HISTORY_DEPTH_DEFAULT;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam logic [TOTAL_W-1:0] DUR_SAT = {TOTAL_W{1'b1}};
   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
   localparam int SETTLE_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES = 6;
   localparam int PHASE_EVENTS = 95;

   typedef struct packed {
      logic [DATA_W-1:0] read_size;
      logic              more_pending;
   } grant_type;

   logic clock = 1'b0;
   logic reset;

   swrl_req_if req_chan ();
   swrl_rsp_if rsp_chan ();
   swrl_csr_if csr_chan ();

   sliding_window_read_rate_limiter_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [DATA_W-1:0]  lim_speed;
   logic [DATA_W-1:0]  lim_window;
   logic [TOTAL_W-1:0] dur_sum;
   logic [TOTAL_W-1:0] byte_sum;
   logic [DATA_W-1:0]  hist_dur [DEPTH];
   logic [DATA_W-1:0]  hist_grant [DEPTH];
   int unsigned        hist_head;
   int unsigned        hist_count;

   grant_type pending_grants [$];
   int     mismatches = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     idle_cycles = 0;

   task automatic reset_model();
      lim_speed  = SPEED_LIMIT_RESET;
      lim_window = WINDOW_MS_RESET;
      dur_sum    = '0;
      byte_sum   = '0;
      hist_head  = 0;
      hist_count = 0;
   endtask

   task automatic apply_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
      if (idx == REG_SPEED_LIMIT) begin
         lim_speed = val;
      end else if (idx == REG_WINDOW_MS) begin
         lim_window = val;
      end
   endtask

   task automatic retire_oldest();
      dur_sum  = (dur_sum > hist_dur[hist_head]) ? dur_sum - hist_dur[hist_head] : '0;
      byte_sum = (byte_sum > hist_grant[hist_head]) ? byte_sum - hist_grant[hist_head] : '0;
      hist_head = (hist_head + 1) % DEPTH;
      hist_count--;
   endtask

   task automatic compute_grant(input logic [DATA_W-1:0] elapsed,
                                input logic [DATA_W-1:0] avail, output grant_type g);
      logic [TOTAL_W:0]          sum;
      logic [PROD_W-1:0]         allow;
      logic [PROD_W-1:0]         diff;
      logic [DATA_W-1:0]         grant;
      int unsigned               slot;
      grant = avail;
      sum = {1'b0, dur_sum} + elapsed;
      dur_sum = (sum > {1'b0, DUR_SAT}) ? DUR_SAT : sum[TOTAL_W-1:0];
      while (dur_sum > {{(TOTAL_W-DATA_W){1'b0}}, lim_window} && hist_count > 0)
         retire_oldest();
      if (dur_sum != '0 && lim_speed != '0) begin
         allow = ({{DATA_W{1'b0}}, dur_sum} * {{TOTAL_W{1'b0}}, lim_speed}) / MS_PER_S;
         if (allow <= {{DATA_W{1'b0}}, byte_sum}) begin
            grant = '0;
         end else begin
            diff = allow - {{DATA_W{1'b0}}, byte_sum};
            grant = (diff < {{TOTAL_W{1'b0}}, avail}) ? diff[DATA_W-1:0] : avail;
         end
      end
      if (hist_count >= DEPTH)
         retire_oldest();
      slot = (hist_head + hist_count) % DEPTH;
      hist_dur[slot]   = elapsed;
      hist_grant[slot] = grant;
      hist_count++;
      byte_sum = byte_sum + grant;
      g.read_size    = grant;
      g.more_pending = (avail > grant);
   endtask

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_val,
                                  input logic [DATA_W-1:0] got_val);
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_val, got_val, $realtime);
      mismatches++;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      grant_type exp_g;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected transfer, read_size", '0, rsp_chan.read_size);
         end else begin
            exp_g = pending_grants[0];
            pending_grants.delete(0);
            if (rsp_chan.read_size !== exp_g.read_size)
               report_mismatch("read_size", exp_g.read_size, rsp_chan.read_size);
            if (rsp_chan.more_pending !== exp_g.more_pending)
               report_mismatch("more_pending", exp_g.more_pending, rsp_chan.more_pending);
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_event(input logic [DATA_W-1:0] elapsed, input logic [DATA_W-1:0] avail);
      grant_type g;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.elapsed_ms      <= elapsed;
      req_chan.available_bytes <= avail;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      compute_grant(elapsed, avail, g);
      pending_grants.push_back(g);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      apply_reg(idx, val);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_speed();
      case ($urandom_range(6))
         0: return '0;
         1: return ALL_ONES;
         2: return 32'd1;
         3: return SPEED_LIMIT_RESET;
         4: return $urandom_range(1, 100000);
         5: return $urandom();
         default: return $urandom_range(1000, 10000000);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_window();
      case ($urandom_range(5))
         0: return 32'd1;
         1: return ALL_ONES;
         2: return WINDOW_MS_RESET;
         3: return $urandom_range(1, 100);
         4: return $urandom_range(100, 100000);
         default: return $urandom() | 32'd1;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_elapsed(input bit dense);
      int unsigned r;
      r = $urandom_range(99);
      if (dense && r < 70)
         return $urandom_range(0, 1000);
      if (r < 50)
         return $urandom_range(0, (lim_window > 64) ? lim_window / 32 : lim_window);
      if (r < 80)
         return $urandom_range(0, lim_window);
      if (r < 90)
         return '0;
      if (r < 95)
         return ALL_ONES;
      return $urandom();
   endfunction

   function automatic logic [DATA_W-1:0] pick_avail();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)
         return '0;
      if (r < 15)
         return ALL_ONES;
      if (r < 55)
         return $urandom_range(0, 5000);
      if (r < 80)
         return $urandom_range(0, 1 << 20);
      return $urandom();
   endfunction

   // reset register values; first event with zero elapsed has a zero total
   task automatic test_reset_config();
      send_event(32'd0, 32'd100);
      send_event(32'd1000, ALL_ONES);
      send_event(ALL_ONES, 32'd0);
      send_event(32'd5, 32'd4000);
      settle();
   endtask

   task automatic test_speed_disabled();
      write_reg(REG_SPEED_LIMIT, '0);
      send_event(32'd5, ALL_ONES);
      send_event(32'd0, 32'd0);
      send_event(32'd20, 32'd123456);
      settle();
   endtask

   // slow limit: allowance falls below the byte total, grant drops to zero
   task automatic test_deficit_grant();
      write_reg(REG_SPEED_LIMIT, 32'd1);
      write_reg(REG_WINDOW_MS, ALL_ONES);
      send_event(32'd2000, 32'd10);
      send_event(32'd1, 32'd10);
      send_event(32'd999, 32'd1);
      settle();
   endtask

   task automatic test_window_retire();
      write_reg(REG_SPEED_LIMIT, 32'd1000);
      write_reg(REG_WINDOW_MS, 32'd1);
      send_event(32'd1, 32'd50);
      send_event(32'd2, 32'd50);
      send_event(32'd0, 32'd50);
      settle();
   endtask

   task automatic test_field_extremes();
      write_reg(REG_SPEED_LIMIT, ALL_ONES);
      write_reg(REG_WINDOW_MS, ALL_ONES);
      send_event(ALL_ONES, ALL_ONES);
      send_event(32'd0, 32'd0);
      send_event(ALL_ONES, 32'd0);
      send_event(32'd0, ALL_ONES);
      settle();
   endtask

   // writes to spare indexes leave both registers alone
   task automatic test_spare_index();
      write_reg(REG_SPEED_LIMIT, 32'd3000);
      write_reg(REG_WINDOW_MS, 32'd500);
      write_reg(REG_SPARE_2, $urandom());
      write_reg(REG_SPARE_3, $urandom());
      send_event(32'd100, 32'd1000);
      send_event(32'd450, 32'd5000);
      settle();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      logic [DATA_W-1:0] spd;
      logic [DATA_W-1:0] win;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin spd = pick_speed(); win = ALL_ONES; end
            1: begin spd = ALL_ONES; win = pick_window(); end
            2: begin spd = '0; win = pick_window(); end
            3: begin spd = pick_speed(); win = 32'd1; end
            default: begin spd = pick_speed(); win = pick_window(); end
         endcase
         write_reg(REG_SPEED_LIMIT, spd);
         write_reg(REG_WINDOW_MS, win);
         for (int n = 0; n < PHASE_EVENTS; n++)
            send_event(pick_elapsed(ph == 0 || ph == 5), pick_avail());
         settle();
      end
   endtask

   initial begin
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.elapsed_ms      <= '0;
      req_chan.available_bytes <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.index           <= '0;
      csr_chan.data            <= '0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 34;
      recv_idle_pct = 84;
      test_reset_config();
      test_speed_disabled();
      test_deficit_grant();
      test_window_retire();
      test_field_extremes();
      test_spare_index();
      test_random_traffic(34, 84);
      test_random_traffic(84, 34);
      test_random_traffic(0, 0);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/swrl_pkg.sv
rtl/swrl_req_if.sv
rtl/swrl_rsp_if.sv
rtl/swrl_csr_if.sv
rtl/swrl_ctrl.sv
rtl/swrl_dp.sv
rtl/sliding_window_read_rate_limiter_unit.sv
tb/tb_sliding_window_read_rate_limiter_unit.sv
